// ===== rtl/indexed_min_heap_macros.svh =====
// ----------------------------------------------------------------------------
// indexed_min_heap assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IMH_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IMH_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMH_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// shared constants and types of the indexed min-heap
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
	localparam int NODE_COUNT = 1024;
	localparam int PRIO_W     = 32;
	localparam int KEY_W      = 10;
	localparam int SLOT_W     = 11;
	localparam int OP_W       = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELMIN = 2'd1;
	localparam logic [OP_W-1:0] OP_DECKEY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} entry_t;
endpackage
`default_nettype wire

// ===== rtl/imh_ram.sv =====
// ----------------------------------------------------------------------------
// imh_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/indexed_min_heap.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap
// indexed binary min-heap with key position map and decrease-key
// ----------------------------------------------------------------------------
// channel   | handshake        | fields
// request   | start / busy     | operation, node_key, priority_req
// result    | done (1 cycle)   | accepted, key_was_present, min_valid,
//           |                  | min_key, min_priority, heap_count
//
// one request at a time; as slot ram reads are registered, each heap level
// passes S_UP_RD, S_UP_CMP going up and S_DN_RD, S_DN_C1, S_DN_C2 (right
// child only), S_DN_DEC going down. busy stays high through a request;
// done follows in the next cycle. after reset all 1024 position map entries
// are cleared, busy high. the receiver cannot hold off the result strobe.
`default_nettype none
`include "indexed_min_heap_macros.svh"
module indexed_min_heap (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [imh_pkg::OP_W-1:0]      operation,
	input  wire logic [imh_pkg::KEY_W-1:0]     node_key,
	input  wire logic [imh_pkg::PRIO_W-1:0]    priority_req,
	output logic                               done,
	output logic                               accepted,
	output logic                               key_was_present,
	output logic                               min_valid,
	output logic [imh_pkg::KEY_W-1:0]          min_key,
	output logic [imh_pkg::PRIO_W-1:0]         min_priority,
	output logic [imh_pkg::SLOT_W-1:0]         heap_count
);
	import imh_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOKUP, S_DEL_LAST, S_DEC_CMP, S_UP_RD, S_UP_CMP,
		S_DN_RD, S_DN_C1, S_DN_C2, S_DN_DEC, S_FIN, S_RESP
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] clr_q, count_q, pos_q, cidx_q;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [PRIO_W-1:0] prio_q;
	logic              present_q, ok_q;
	entry_t            cur_q, child_q, root_q;
	logic              done_q, acc_q, pres_out_q, mv_q;
	logic [KEY_W-1:0]  mk_q;
	logic [PRIO_W-1:0] mp_q;
	logic [SLOT_W-1:0] hc_q;

	logic              h_we, m_we;
	logic [SLOT_W-1:0] h_waddr, h_raddr, m_wdata, m_rdata;
	entry_t            h_wdata, h_rdata;
	logic [KEY_W-1:0]  m_waddr, m_raddr;
	logic [SLOT_W:0]   c_idx, c1_idx;

	assign c_idx  = {pos_q, 1'b0};
	assign c1_idx = c_idx + (SLOT_W+1)'(1);

	imh_ram #(.WIDTH(KEY_W + PRIO_W), .DEPTH(NODE_COUNT + 1), .AW(SLOT_W)) u_slots (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	imh_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT), .AW(KEY_W)) u_map (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	always_comb begin
		h_we = 1'b0; h_waddr = '0; h_wdata = cur_q; h_raddr = '0;
		m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = node_key;
		unique case (state_q)
			S_CLEAR: begin
				m_we = 1'b1;
				m_waddr = clr_q[KEY_W-1:0];
			end
			S_LOOKUP: begin
				if (op_q == OP_DELMIN && count_q != '0) begin
					m_we = 1'b1;
					m_waddr = root_q.key;
					h_raddr = count_q;
				end else begin
					h_raddr = m_rdata;
				end
			end
			S_UP_RD: h_raddr = pos_q >> 1;
			S_UP_CMP: begin
				// parent moves down into the hole
				if (cur_q.prio < h_rdata.prio) begin
					h_we = 1'b1; h_waddr = pos_q; h_wdata = h_rdata;
					m_we = 1'b1; m_waddr = h_rdata.key; m_wdata = pos_q;
				end
			end
			S_DN_RD: h_raddr = c_idx[SLOT_W-1:0];
			S_DN_C1: h_raddr = c1_idx[SLOT_W-1:0];
			S_DN_DEC: begin
				if (child_q.prio < cur_q.prio) begin
					h_we = 1'b1; h_waddr = pos_q; h_wdata = child_q;
					m_we = 1'b1; m_waddr = child_q.key; m_wdata = pos_q;
				end
			end
			S_FIN: begin
				h_we = 1'b1; h_waddr = pos_q; h_wdata = cur_q;
				m_we = 1'b1; m_waddr = cur_q.key; m_wdata = pos_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0; count_q <= '0; pos_q <= '0; cidx_q <= '0;
			op_q <= '0; key_q <= '0; prio_q <= '0;
			present_q <= 1'b0; ok_q <= 1'b0;
			cur_q <= '0; child_q <= '0; root_q <= '0;
			done_q <= 1'b0; acc_q <= 1'b0; pres_out_q <= 1'b0; mv_q <= 1'b0;
			mk_q <= '0; mp_q <= '0; hc_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (h_we && h_waddr == SLOT_W'(1))
				root_q <= h_wdata;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(NODE_COUNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						key_q <= node_key;
						prio_q <= priority_req;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					present_q <= m_rdata != '0;
					ok_q <= 1'b0;
					pos_q <= m_rdata;
					state_q <= S_RESP;
					case (op_q)
						OP_INSERT: begin
							if (m_rdata == '0 && count_q < SLOT_W'(NODE_COUNT)) begin
								count_q <= count_q + SLOT_W'(1);
								pos_q <= count_q + SLOT_W'(1);
								cur_q <= '{key: key_q, prio: prio_q};
								ok_q <= 1'b1;
								state_q <= S_UP_RD;
							end
						end
						OP_DELMIN: begin
							if (count_q != '0) begin
								ok_q <= 1'b1;
								count_q <= count_q - SLOT_W'(1);
								if (count_q != SLOT_W'(1))
									state_q <= S_DEL_LAST;
							end
						end
						OP_DECKEY: begin
							if (m_rdata != '0)
								state_q <= S_DEC_CMP;
						end
						default: ;
					endcase
				end
				S_DEL_LAST: begin
					cur_q <= h_rdata;
					pos_q <= SLOT_W'(1);
					state_q <= S_DN_RD;
				end
				S_DEC_CMP: begin
					if (!(h_rdata.prio < prio_q)) begin
						ok_q <= 1'b1;
						cur_q <= '{key: key_q, prio: prio_q};
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_UP_RD: state_q <= (pos_q == SLOT_W'(1)) ? S_FIN : S_UP_CMP;
				S_UP_CMP: begin
					if (cur_q.prio < h_rdata.prio) begin
						pos_q <= pos_q >> 1;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_RD: state_q <= (c_idx > {1'b0, count_q}) ? S_FIN : S_DN_C1;
				S_DN_C1: begin
					child_q <= h_rdata;
					cidx_q <= c_idx[SLOT_W-1:0];
					state_q <= (c1_idx <= {1'b0, count_q}) ? S_DN_C2 : S_DN_DEC;
				end
				S_DN_C2: begin
					// right child wins only when strictly smaller
					if (h_rdata.prio < child_q.prio) begin
						child_q <= h_rdata;
						cidx_q <= c1_idx[SLOT_W-1:0];
					end
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					if (child_q.prio < cur_q.prio) begin
						pos_q <= cidx_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_RESP;
				S_RESP: begin
					done_q <= 1'b1;
					acc_q <= ok_q;
					pres_out_q <= present_q;
					mv_q <= count_q != '0;
					mk_q <= (count_q != '0) ? root_q.key : '0;
					mp_q <= (count_q != '0) ? root_q.prio : '0;
					hc_q <= count_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign accepted        = acc_q;
	assign key_was_present = pres_out_q;
	assign min_valid       = mv_q;
	assign min_key         = mk_q;
	assign min_priority    = mp_q;
	assign heap_count      = hc_q;

	`IMH_NEVER(a_done_single, clk, arst_n, done && $past(done), "result strobe lasted two cycles")
	`IMH_ASSERT(a_min_valid, clk, arst_n, done |-> (min_valid == (heap_count != '0)), "min_valid wrong")
	`IMH_ASSERT(a_count_max, clk, arst_n, done |-> (heap_count <= SLOT_W'(NODE_COUNT)), "count overflow")
	`IMH_NEVER(a_done_busy, clk, arst_n, done && busy, "result while busy")
endmodule
`default_nettype wire

// ===== tb/sv/indexed_min_heap_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_tb
// drives insert, delete-min, decrease-key and invalid requests into the indexed heap
// and checks every result against a behavioral heap kept alongside it
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import imh_pkg::*;

	localparam logic [OP_W-1:0] OP_BAD = 2'd3;

	typedef struct packed {
		logic              ok;
		logic              present;
		logic              vld;
		logic [KEY_W-1:0]  mkey;
		logic [PRIO_W-1:0] mprio;
		logic [SLOT_W-1:0] cnt;
	} heap_status_t;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
		bit                fixed;
		heap_status_t      status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] operation = OP_INSERT;
	logic [KEY_W-1:0] node_key = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic busy, done, accepted, key_was_present, min_valid;
	logic [KEY_W-1:0] min_key;
	logic [PRIO_W-1:0] min_priority;
	logic [SLOT_W-1:0] heap_count;

	indexed_min_heap u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .node_key(node_key), .priority_req(priority_req),
		.done(done), .accepted(accepted), .key_was_present(key_was_present),
		.min_valid(min_valid), .min_key(min_key), .min_priority(min_priority),
		.heap_count(heap_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// behavioral heap
	logic [KEY_W-1:0]  hk [1:NODE_COUNT];
	logic [PRIO_W-1:0] hp [1:NODE_COUNT];
	int unsigned       kpos [0:NODE_COUNT-1];
	int unsigned       hsize = 0;

	heap_status_t pending_status [$];
	int errors = 0;

	function automatic void swap_slot(int unsigned a, int unsigned b);
		logic [KEY_W-1:0] k;
		logic [PRIO_W-1:0] p;
		k = hk[a]; p = hp[a];
		hk[a] = hk[b]; hp[a] = hp[b];
		hk[b] = k; hp[b] = p;
		kpos[hk[a]] = a;
		kpos[hk[b]] = b;
	endfunction

	function automatic void bubble_up(int unsigned pos);
		while (pos > 1 && hp[pos] < hp[pos/2]) begin
			swap_slot(pos, pos/2);
			pos = pos/2;
		end
	endfunction

	function automatic heap_status_t apply_request(logic [OP_W-1:0] op,
			logic [KEY_W-1:0] key, logic [PRIO_W-1:0] prio);
		heap_status_t s;
		int unsigned pos, c, last;
		s = '0;
		s.present = kpos[key] != 0;
		case (op)
			OP_INSERT: begin
				if (!s.present && hsize < NODE_COUNT) begin
					hsize++;
					hk[hsize] = key; hp[hsize] = prio; kpos[key] = hsize;
					bubble_up(hsize);
					s.ok = 1'b1;
				end
			end
			OP_DELMIN: begin
				if (hsize != 0) begin
					last = hsize;
					kpos[hk[1]] = 0;
					hsize--;
					if (hsize != 0) begin
						hk[1] = hk[last]; hp[1] = hp[last]; kpos[hk[1]] = 1;
						pos = 1;
						while (2*pos <= hsize) begin
							c = 2*pos;
							if (c+1 <= hsize && hp[c+1] < hp[c]) c = c+1;
							if (!(hp[c] < hp[pos])) break;
							swap_slot(pos, c);
							pos = c;
						end
					end
					s.ok = 1'b1;
				end
			end
			OP_DECKEY: begin
				if (s.present) begin
					pos = kpos[key];
					if (!(hp[pos] < prio)) begin
						hp[pos] = prio;
						bubble_up(pos);
						s.ok = 1'b1;
					end
				end
			end
			default: ;
		endcase
		s.vld = hsize != 0;
		s.mkey = s.vld ? hk[1] : '0;
		s.mprio = s.vld ? hp[1] : '0;
		s.cnt = SLOT_W'(hsize);
		return s;
	endfunction

	// result checker, samples on the edge that ends the strobe cycle
	always @(posedge clk) begin
		heap_status_t e;
		if (arst_n && done) begin
			if (pending_status.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = pending_status.pop_front();
				if (accepted !== e.ok) begin
					$error("accepted exp %0d got %0d", e.ok, accepted); errors++;
				end
				if (key_was_present !== e.present) begin
					$error("key_was_present exp %0d got %0d", e.present, key_was_present);
					errors++;
				end
				if (min_valid !== e.vld) begin
					$error("min_valid exp %0d got %0d", e.vld, min_valid); errors++;
				end
				if (min_key !== e.mkey) begin
					$error("min_key exp %0d got %0d", e.mkey, min_key); errors++;
				end
				if (min_priority !== e.mprio) begin
					$error("min_priority exp %0h got %0h", e.mprio, min_priority); errors++;
				end
				if (heap_count !== e.cnt) begin
					$error("heap_count exp %0d got %0d", e.cnt, heap_count); errors++;
				end
			end
		end
	end

	// one request, with random idle before it unless quiet
	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [PRIO_W-1:0] prio, bit quiet);
		heap_status_t s;
		while (!quiet && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		node_key <= key;
		priority_req <= prio;
		do @(posedge clk); while (busy);
		s = apply_request(op, key, prio);
		pending_status.push_back(s);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic heap_status_t st(bit ok, bit pr, bit v, int k, logic [31:0] p,
			int c);
		heap_status_t s;
		s.ok = ok; s.present = pr; s.vld = v; s.mkey = KEY_W'(k); s.mprio = p;
		s.cnt = SLOT_W'(c);
		return s;
	endfunction

	stim_row_t dir_rows [$];

	function automatic void add_row(logic [OP_W-1:0] op, int key, logic [31:0] prio,
			bit fixed = 0, heap_status_t s = '0);
		stim_row_t r;
		r.op = op; r.key = KEY_W'(key); r.prio = prio; r.fixed = fixed; r.status = s;
		dir_rows.push_back(r);
	endfunction

	// keys from a pool of the given size; a small pool makes repeats and decreases common
	function automatic logic [KEY_W-1:0] pick_key(int pool);
		return (pool >= NODE_COUNT) ? KEY_W'($urandom) : KEY_W'($urandom_range(pool-1));
	endfunction

	function automatic logic [PRIO_W-1:0] pick_prio();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return 32'hFFFF_FFFF - $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] k;
		int pool, r;
		bit quiet;
		for (int i = 0; i < NODE_COUNT; i++) kpos[i] = 0;

		// empty heap, extremes, equal priorities, bad opcode
		add_row(OP_DELMIN, 0, 0, 1, st(0, 0, 0, 0, 0, 0));
		add_row(OP_DECKEY, 5, 0, 1, st(0, 0, 0, 0, 0, 0));
		add_row(OP_BAD, 1023, 32'hFFFF_FFFF, 1, st(0, 0, 0, 0, 0, 0));
		add_row(OP_INSERT, 1023, 32'hFFFF_FFFF, 1, st(1, 0, 1, 1023, 32'hFFFF_FFFF, 1));
		add_row(OP_INSERT, 1023, 0, 1, st(0, 1, 1, 1023, 32'hFFFF_FFFF, 1));
		add_row(OP_INSERT, 0, 32'h5555_5555);
		add_row(OP_INSERT, 682, 32'hAAAA_AAAA);
		add_row(OP_INSERT, 341, 32'h5555_5555);
		add_row(OP_INSERT, 7, 100);
		add_row(OP_DECKEY, 7, 200);
		add_row(OP_DECKEY, 7, 100);
		add_row(OP_DECKEY, 1023, 0);
		add_row(OP_DECKEY, 682, 32'h5555_5555);
		add_row(OP_BAD, 7, 0);
		add_row(OP_DELMIN, 1023, 0);
		add_row(OP_DELMIN, 0, 0);
		add_row(OP_DECKEY, 1023, 5);
		add_row(OP_DELMIN, 0, 0);
		add_row(OP_DELMIN, 0, 0);
		add_row(OP_DELMIN, 0, 0);
		add_row(OP_DELMIN, 0, 0);
		add_row(OP_DELMIN, 0, 0, 1, st(0, 0, 0, 0, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].fixed) begin
				// typed-in expectation must also agree with the predictor
				send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].prio, 0);
				if (pending_status[$] !== dir_rows[i].status) begin
					$error("directed row %0d expectation disagrees with predictor", i);
					errors++;
				end
				pending_status[$] = dir_rows[i].status;
			end else
				send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].prio, 0);
		end
		drain_results();

		// random phase: grow, churn, shrink, plus a quiet stretch
		for (int n = 0; n < 1530; n++) begin
			quiet = (n >= 600 && n < 800);
			pool = (n < 500) ? 48 : NODE_COUNT;
			r = $urandom_range(99);
			if (n < 1100) op = (r < 50) ? OP_INSERT : (r < 75) ? OP_DECKEY :
				(r < 97) ? OP_DELMIN : OP_BAD;
			else op = (r < 70) ? OP_DELMIN : (r < 85) ? OP_INSERT : OP_DECKEY;
			k = pick_key(pool);
			if (op == OP_DECKEY && hsize != 0 && $urandom_range(3) != 0)
				k = hk[$urandom_range(hsize, 1)];
			if (op == OP_DECKEY && kpos[k] != 0 && $urandom_range(1))
				send_request(op, k, hp[kpos[k]] - $urandom_range(3), quiet);
			else
				send_request(op, k, pick_prio(), quiet);
			if (n == 900) drain_results();
		end
		drain_results();

		if (errors == 0 && pending_status.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/indexed_min_heap.sv
tb/sv/indexed_min_heap_tb.sv
